[sv/vhs_pkg.sv]
`default_nettype none
package vhs_pkg;

  localparam int NUM_BUCKETS  = 256;
  localparam int BUCKET_DEPTH = 8;
  localparam int MAX_KEY_LEN  = 16;
  localparam int ELEM_WIDTH   = 16;
  localparam int HASH_MULT    = 1997;

  localparam int BUCKET_W = $clog2(NUM_BUCKETS);
  localparam int SLOT_W   = $clog2(BUCKET_DEPTH);
  localparam int POS_W    = $clog2(MAX_KEY_LEN);
  localparam int CNT_W    = $clog2(BUCKET_DEPTH + 1);
  localparam int LEN_W    = 5;
  localparam int STAT_W   = 3;
  localparam int KS_ADDR_W = BUCKET_W + SLOT_W + POS_W;

  // multiplier reduced mod bucket count; only the low hash bits survive
  localparam logic [BUCKET_W-1:0] HASH_MULT_LO = BUCKET_W'(HASH_MULT % NUM_BUCKETS);

  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STAT_W-1:0] ST_ABSENT   = 3'd4;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_FIND = 1'b1;

  typedef struct packed {
    logic                         cmd;
    logic signed [ELEM_WIDTH-1:0] elem_value;
  } vhs_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [7:0]        bucket;
  } vhs_out_t;

  typedef enum logic [2:0] {
    S_RECV,
    S_CNT,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_WRITE,
    S_RESP
  } vhs_state_t;

endpackage
`default_nettype wire

[sv/vector_hash_set.sv]
// Non-final elements: one per cycle, no result. After the final element the FSM goes
// through CNT, then SCAN and DRAIN unless the bucket is empty, then DECIDE, then WRITE
// for an insert (all MAX_KEY_LEN positions), then RESP; the key store does one compare
// or one write a cycle. in_ready returns the cycle after the result register loads,
// which waits while an earlier result is still held there; no new key is taken until then.
// Synchronous active-low reset: bucket valid flags, hash and position clear, key_len to 16.
`default_nettype none
module vector_hash_set (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vhs_pkg::vhs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output vhs_pkg::vhs_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [4:0]        cfg_data
);
  import vhs_pkg::*;

  vhs_state_t state_r, state_nxt;

  logic [LEN_W-1:0]    key_len_r;
  logic [BUCKET_W-1:0] rh_r;
  logic [POS_W-1:0]    eidx_r;
  logic [ELEM_WIDTH-1:0] kbuf_r [MAX_KEY_LEN];

  logic [BUCKET_W-1:0] hash_r;
  logic                cmd_r;
  logic [POS_W-1:0]    len_m1_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [POS_W-1:0]    idx_r;
  logic [POS_W-1:0]    widx_r;
  logic                present_r;
  logic                mism_r;
  logic [STAT_W-1:0]   status_r;

  logic                cmp_vld_r;
  logic                cmp_last_r;
  logic [POS_W-1:0]    cmp_idx_r;

  logic [NUM_BUCKETS-1:0] bvalid_r;
  logic [CNT_W-1:0]       bcnt_mem [NUM_BUCKETS];
  logic [CNT_W-1:0]       cnt_q;
  logic [ELEM_WIDTH-1:0]  ks_mem [2**KS_ADDR_W];
  logic [ELEM_WIDTH-1:0]  ks_q;

  logic                out_valid_r;
  vhs_out_t            out_data_r;

  logic [LEN_W-1:0]    len_eff;
  logic [BUCKET_W-1:0] prod_term;
  logic [BUCKET_W-1:0] prod_mul;
  logic [BUCKET_W-1:0] h_cur;
  logic                last_elem;
  logic                in_fire;
  logic [CNT_W-1:0]    cnt_eff;
  logic                issue_last;
  logic                do_insert;
  logic                resp_load;
  logic                mism_now;
  logic [KS_ADDR_W-1:0] rd_addr;
  logic [KS_ADDR_W-1:0] wr_addr;
  logic [ELEM_WIDTH-1:0] wr_data;

  // key_len 0 behaves as 1, anything above the maximum as the maximum
  always_comb begin
    if (key_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (key_len_r > LEN_W'(MAX_KEY_LEN)) begin
      len_eff = LEN_W'(MAX_KEY_LEN);
    end else begin
      len_eff = key_len_r;
    end
  end

  // position * element mod 256 only needs the low element byte
  assign prod_term = BUCKET_W'(eidx_r) * in_data.elem_value[BUCKET_W-1:0];
  assign prod_mul  = rh_r * HASH_MULT_LO;
  assign h_cur     = prod_mul + prod_term;
  assign last_elem = ({1'b0, eidx_r} + LEN_W'(1)) >= len_eff;
  assign in_fire   = in_valid && in_ready;

  assign cnt_eff    = bvalid_r[hash_r] ? cnt_q : '0;
  assign issue_last = (idx_r == len_m1_r) && ({1'b0, slot_r} == (cnt_r - CNT_W'(1)));
  assign do_insert  = (cmd_r == CMD_ADD) && !present_r && (cnt_r < CNT_W'(BUCKET_DEPTH));
  assign resp_load  = (state_r == S_RESP) && (!out_valid_r || out_ready);
  assign mism_now   = mism_r || (ks_q != kbuf_r[cmp_idx_r]);

  assign rd_addr = {hash_r, slot_r, idx_r};
  assign wr_addr = {hash_r, cnt_r[SLOT_W-1:0], widx_r};
  assign wr_data = ({1'b0, widx_r} <= {1'b0, len_m1_r}) ? kbuf_r[widx_r] : '0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_RECV: begin
        if (in_fire && last_elem) begin
          state_nxt = S_CNT;
        end
      end
      S_CNT: begin
        state_nxt = (cnt_eff == '0) ? S_DECIDE : S_SCAN;
      end
      S_SCAN: begin
        if (issue_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:  state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = do_insert ? S_WRITE : S_RESP;
      S_WRITE: begin
        if (widx_r == POS_W'(MAX_KEY_LEN - 1)) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (resp_load) begin
          state_nxt = S_RECV;
        end
      end
      default: state_nxt = S_RECV;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == S_RECV);
    cfg_ready = 1'b1;
    out_valid = out_valid_r;
    out_data  = out_data_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RECV;
      key_len_r   <= LEN_W'(MAX_KEY_LEN);
      rh_r        <= '0;
      eidx_r      <= '0;
      bvalid_r    <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        key_len_r <= cfg_data;
      end
      if (in_fire) begin
        if (last_elem) begin
          rh_r   <= '0;
          eidx_r <= '0;
        end else begin
          rh_r   <= h_cur;
          eidx_r <= eidx_r + POS_W'(1);
        end
      end
      cmp_vld_r <= (state_r == S_SCAN);
      if ((state_r == S_WRITE) && (widx_r == POS_W'(MAX_KEY_LEN - 1))) begin
        bvalid_r[hash_r] <= 1'b1;
      end
      if (resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kbuf_r[eidx_r] <= in_data.elem_value;
      if (last_elem) begin
        hash_r   <= h_cur;
        cmd_r    <= in_data.cmd;
        len_m1_r <= POS_W'(len_eff - LEN_W'(1));
      end
    end

    case (state_r)
      S_CNT: begin
        cnt_r     <= cnt_eff;
        slot_r    <= '0;
        idx_r     <= '0;
        widx_r    <= '0;
        present_r <= 1'b0;
        mism_r    <= 1'b0;
      end
      S_SCAN: begin
        if (idx_r == len_m1_r) begin
          idx_r  <= '0;
          slot_r <= slot_r + SLOT_W'(1);
        end else begin
          idx_r <= idx_r + POS_W'(1);
        end
      end
      S_DECIDE: begin
        if (cmd_r == CMD_FIND) begin
          status_r <= present_r ? ST_FOUND : ST_ABSENT;
        end else if (present_r) begin
          status_r <= ST_PRESENT;
        end else if (cnt_r >= CNT_W'(BUCKET_DEPTH)) begin
          status_r <= ST_FULL;
        end else begin
          status_r <= ST_INSERTED;
        end
      end
      S_WRITE: begin
        widx_r <= widx_r + POS_W'(1);
      end
      default: begin
      end
    endcase

    // compare stage works on the key-store read issued in the previous cycle
    cmp_idx_r  <= idx_r;
    cmp_last_r <= (idx_r == len_m1_r);
    if (cmp_vld_r) begin
      if (cmp_last_r) begin
        mism_r <= 1'b0;
        if (!mism_now) begin
          present_r <= 1'b1;
        end
      end else begin
        mism_r <= mism_now;
      end
    end

    if (resp_load) begin
      out_data_r.status <= status_r;
      out_data_r.bucket <= 8'(hash_r);
    end
  end

  // bucket count store
  always_ff @(posedge clk) begin
    cnt_q <= bcnt_mem[h_cur];
    if ((state_r == S_WRITE) && (widx_r == POS_W'(MAX_KEY_LEN - 1))) begin
      bcnt_mem[hash_r] <= cnt_r + CNT_W'(1);
    end
  end

  // key store
  always_ff @(posedge clk) begin
    ks_q <= ks_mem[rd_addr];
    if (state_r == S_WRITE) begin
      ks_mem[wr_addr] <= wr_data;
    end
  end

endmodule
`default_nettype wire
